// ===== src/plist_pkg.sv =====
// Shared types, codes and size constants for the positional list engine.
// Used by plist_cell and positional_list_engine; no dependencies.
`default_nettype none

package plist_pkg;

  localparam int DEPTH_DEF    = 32;
  localparam int KEY_BITS_DEF = 16;

  // Wide enough for a count of up to 64 entries and any 6-bit position.
  localparam int CNT_BITS = 7;

  // Request codes
  localparam logic [2:0] REQ_INS_FRONT = 3'd0;
  localparam logic [2:0] REQ_INS_BACK  = 3'd1;
  localparam logic [2:0] REQ_INS_POS   = 3'd2;
  localparam logic [2:0] REQ_REM_FRONT = 3'd3;
  localparam logic [2:0] REQ_REM_BACK  = 3'd4;
  localparam logic [2:0] REQ_REM_POS   = 3'd5;
  localparam logic [2:0] REQ_DUMP      = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // Cell operations
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_REM  = 2'd2;
  localparam logic [1:0] OP_ROT  = 2'd3;

  typedef struct packed {
    logic [1:0]          op;
    logic [CNT_BITS-1:0] at;   // target position
    logic [CNT_BITS-1:0] cnt;  // current entry count
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/plist_cell.sv =====
// One slot of the list chain: holds a key and shifts to/from its neighbors.
// Depends on plist_pkg.
`default_nettype none

module plist_cell #(
  parameter int KEY_BITS = plist_pkg::KEY_BITS_DEF,
  parameter int IDX      = 0
) (
  input  wire logic                 clk,
  input  wire plist_pkg::cell_ctl_t ctl,
  input  wire logic [KEY_BITS-1:0]  key_in,
  input  wire logic [KEY_BITS-1:0]  left_q,
  input  wire logic [KEY_BITS-1:0]  right_q,
  input  wire logic [KEY_BITS-1:0]  head_q,
  output logic      [KEY_BITS-1:0]  q
);

  localparam logic [plist_pkg::CNT_BITS-1:0] MY_IDX = plist_pkg::CNT_BITS'(IDX);
  localparam logic [plist_pkg::CNT_BITS-1:0] MY_P1  = plist_pkg::CNT_BITS'(IDX + 1);

  always_ff @(posedge clk) begin
    case (ctl.op)
      plist_pkg::OP_INS: begin
        if (MY_IDX == ctl.at) begin
          q <= key_in;
        end else if (MY_IDX > ctl.at) begin
          q <= left_q;
        end
      end
      plist_pkg::OP_REM: begin
        if (MY_IDX >= ctl.at) begin
          q <= right_q;
        end
      end
      plist_pkg::OP_ROT: begin
        // tail of the live region takes the head, the rest move forward
        if (MY_P1 == ctl.cnt) begin
          q <= head_q;
        end else if (MY_P1 < ctl.cnt) begin
          q <= right_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/positional_list_engine.sv =====
// Insert, remove and error results are registered at the clock edge that accepts the request.
// Throughput: one request per cycle while the output side takes each word.
// Dump of N entries: N words, one per cycle unless stalled, by rotating the cell chain;
// no request is taken until the last one is loaded. Empty dump gives a single word.
// Reset: clears the count, state and output valid; cell contents are not cleared.
// Depends on plist_pkg and plist_cell.
`default_nettype none

module positional_list_engine #(
  parameter int DEPTH    = plist_pkg::DEPTH_DEF,
  parameter int KEY_BITS = plist_pkg::KEY_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  req_type,
  input  wire logic [5:0]  position,
  input  wire logic [15:0] entry_key,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [15:0] out_key,
  output logic      [4:0]  out_index,
  output logic      [1:0]  status,
  output logic      [5:0]  entry_count,
  output logic             is_last
);

  localparam int CW = plist_pkg::CNT_BITS;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic                state;
  logic                state_next;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [CW-1:0]       dump_idx;
  logic [CW-1:0]       dump_idx_next;

  logic                accept;
  logic                step;
  logic [CW-1:0]       at;
  logic [1:0]          st;
  logic [KEY_BITS-1:0] rem_key;
  logic [KEY_BITS-1:0] new_key;

  logic                out_valid_next;
  logic                load;
  logic [15:0]         ld_key;
  logic [4:0]          ld_index;
  logic [1:0]          ld_status;
  logic                ld_last;

  plist_pkg::cell_ctl_t ctl;
  logic [KEY_BITS-1:0]  cell_q [DEPTH];

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign step     = (state == S_DUMP) && (!out_valid || out_ready);
  assign new_key  = KEY_BITS'(entry_key);

  // target position per request
  always_comb begin
    case (req_type)
      plist_pkg::REQ_INS_BACK: at = count;
      plist_pkg::REQ_INS_POS,
      plist_pkg::REQ_REM_POS:  at = CW'(position);
      plist_pkg::REQ_REM_BACK: at = (count != '0) ? count - CW'(1) : '0;
      default:                 at = '0;
    endcase
  end

  // key at the remove position
  always_comb begin
    rem_key = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CW'(i) == at) begin
        rem_key = cell_q[i];
      end
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    dump_idx_next = dump_idx;
    ctl.op        = plist_pkg::OP_HOLD;
    ctl.at        = at;
    ctl.cnt       = count;
    load          = 1'b0;
    ld_key        = '0;
    ld_index      = '0;
    ld_status     = plist_pkg::ST_OK;
    ld_last       = 1'b1;
    st            = plist_pkg::ST_OK;

    if (accept) begin
      case (req_type)
        plist_pkg::REQ_INS_FRONT,
        plist_pkg::REQ_INS_BACK,
        plist_pkg::REQ_INS_POS: begin
          load = 1'b1;
          if (count == FULL_CNT) begin
            st = plist_pkg::ST_FULL;
          end else if (at > count) begin
            st = plist_pkg::ST_BADPOS;
          end else begin
            ctl.op     = plist_pkg::OP_INS;
            count_next = count + CW'(1);
            ld_index   = at[4:0];
          end
          ld_status = st;
        end
        plist_pkg::REQ_REM_FRONT,
        plist_pkg::REQ_REM_BACK,
        plist_pkg::REQ_REM_POS: begin
          load = 1'b1;
          if (count == '0) begin
            st = plist_pkg::ST_EMPTY;
          end else if (at >= count) begin
            st = plist_pkg::ST_BADPOS;
          end else begin
            ctl.op     = plist_pkg::OP_REM;
            count_next = count - CW'(1);
            ld_index   = at[4:0];
            ld_key     = 16'(rem_key);
          end
          ld_status = st;
        end
        plist_pkg::REQ_DUMP: begin
          if (count == '0) begin
            load      = 1'b1;
            ld_status = plist_pkg::ST_EMPTY;
          end else begin
            state_next    = S_DUMP;
            dump_idx_next = '0;
          end
        end
        default: begin
          load = 1'b1;
        end
      endcase
    end else if (step) begin
      // head word goes out, chain rotates so the next entry reaches the head
      ctl.op        = plist_pkg::OP_ROT;
      load          = 1'b1;
      ld_key        = 16'(cell_q[0]);
      ld_index      = dump_idx[4:0];
      ld_last       = (dump_idx + CW'(1) == count);
      dump_idx_next = dump_idx + CW'(1);
      if (ld_last) begin
        state_next = S_IDLE;
      end
    end

    out_valid_next = load || (out_valid && !out_ready);
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_BITS-1:0] left_w;
    logic [KEY_BITS-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_q[g+1];
    end
    plist_cell #(
      .KEY_BITS (KEY_BITS),
      .IDX      (g)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .key_in  (new_key),
      .left_q  (left_w),
      .right_q (right_w),
      .head_q  (cell_q[0]),
      .q       (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dump_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      dump_idx  <= dump_idx_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_key     <= ld_key;
      out_index   <= ld_index;
      status      <= ld_status;
      entry_count <= count_next[5:0];
      is_last     <= ld_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count above depth");

  a_dump_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |-> (dump_idx < count))
    else $error("dump index past live entries");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> (count == $past(count)))
    else $error("count changed without a request");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> (count == $past(count) || count == $past(count) + CW'(1) ||
                count + CW'(1) == $past(count)))
    else $error("count moved by more than one");

  a_dump_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |=> (count == $past(count)))
    else $error("count changed during dump");

endmodule

`default_nettype wire
